// ----- rtl/slg_pkg.sv -----
// ----------------------------------------------------------------------------
// slg_pkg
// Shared types, codes and constants of the sparse logistic gradient engine.
// ----------------------------------------------------------------------------
package slg_pkg;

  localparam int IDX_W      = 12;
  localparam int WT_W       = 24;
  localparam int SUM_W      = 32;
  localparam int PROB_W     = 16;
  localparam int GRAD_W     = 48;
  localparam int LOSS_W     = 48;
  localparam int CNT_W      = 32;
  localparam int NLL_W      = 21;
  localparam int IN_DATA_W  = 40;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 152;
  localparam int OUT_USER_W = 1;

  typedef logic [1:0] op_t;
  localparam op_t OP_WRITE   = 2'd0;
  localparam op_t OP_FEATURE = 2'd1;
  localparam op_t OP_READ    = 2'd2;
  localparam op_t OP_CLEAR   = 2'd3;

  localparam logic KIND_PRED = 1'b0;
  localparam logic KIND_GRAD = 1'b1;

  localparam logic [15:0] LN2_Q16 = 16'd45426;

  typedef logic [PROB_W-1:0] prob_t;

  // sigmoid at 0.5 steps over 0..8, Q0.16
  function automatic prob_t sig_point(input logic [4:0] i);
    prob_t v;
    case (i)
      5'd0:    v = 16'd32768;
      5'd1:    v = 16'd40793;
      5'd2:    v = 16'd47911;
      5'd3:    v = 16'd53581;
      5'd4:    v = 16'd57724;
      5'd5:    v = 16'd60565;
      5'd6:    v = 16'd62428;
      5'd7:    v = 16'd63615;
      5'd8:    v = 16'd64357;
      5'd9:    v = 16'd64816;
      5'd10:   v = 16'd65097;
      5'd11:   v = 16'd65269;
      5'd12:   v = 16'd65374;
      5'd13:   v = 16'd65438;
      5'd14:   v = 16'd65476;
      5'd15:   v = 16'd65500;
      default: v = 16'd65514;
    endcase
    return v;
  endfunction

endpackage

// ----- rtl/sparse_logistic_gradient_top.sv -----
// ----------------------------------------------------------------------------
// sparse_logistic_gradient_top
// Sparse binary logistic-regression gradient engine with weight and gradient
// memories, sigmoid prediction and saturating loss accumulation.
// ----------------------------------------------------------------------------
// Use: items enter on the in_ stream. in_tuser selects the operation (write
// weight, record feature, read gradient, clear). A record is one feature
// transfer per active index, in_tlast on its final feature. The final feature
// yields a prediction result; a gradient read yields a gradient result; both
// leave on the out_ stream with out_tuser as the result kind.
// Steps per item: weight write is a write to the weight memory; feature is a
// weight memory read, then the sum; a last feature adds the sigmoid, the log
// unit, the loss accumulate, per buffered feature a buffer read, a gradient
// read and a gradient write (skipped for an out-of-range index), the loop exit
// and the result load; gradient read is a memory read, then the result load;
// clear sweeps the gradient memory one entry per cycle. Prediction latency is
// dominated by the 16 squaring steps of the log unit and the gradient
// read-modify-write loop. Reset: control is cleared and the gradient memory is
// swept to zero with in_tready low. Weights are undefined until written.
// A stalled receiver holds the result in the output register; the block takes
// the next item meanwhile and waits only when it has a new result to load.
// ----------------------------------------------------------------------------
module sparse_logistic_gradient_top #(
  parameter int NUM_WEIGHTS  = 4096,
  parameter int MAX_FEATURES = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // feature_index[11:0], weight_value[35:12], label[36], zero fill
  input  logic [slg_pkg::IN_DATA_W-1:0]     in_tdata,
  // operation[1:0]
  input  logic [slg_pkg::IN_USER_W-1:0]     in_tuser,
  input  logic                              in_tlast,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // probability[15:0], gradient_value[63:16], loss_total[111:64],
  // records_seen[143:112], buffer_overflow[144], zero fill
  output logic [slg_pkg::OUT_DATA_W-1:0]    out_tdata,
  // kind[0]
  output logic [slg_pkg::OUT_USER_W-1:0]    out_tuser
);
  import slg_pkg::*;

  localparam int AW = $clog2(NUM_WEIGHTS);
  localparam int BW = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
  localparam int CW = $clog2(MAX_FEATURES + 1);

  localparam logic [3:0] ST_CLR  = 4'd0;
  localparam logic [3:0] ST_IDLE = 4'd1;
  localparam logic [3:0] ST_FADD = 4'd2;
  localparam logic [3:0] ST_SIG  = 4'd3;
  localparam logic [3:0] ST_LOGS = 4'd4;
  localparam logic [3:0] ST_LOGW = 4'd5;
  localparam logic [3:0] ST_ACC  = 4'd6;
  localparam logic [3:0] ST_GBUF = 4'd7;
  localparam logic [3:0] ST_GRD  = 4'd8;
  localparam logic [3:0] ST_GWR  = 4'd9;
  localparam logic [3:0] ST_EMIT = 4'd10;
  localparam logic [3:0] ST_RD   = 4'd11;

  // memories
  logic signed [WT_W-1:0]   wmem [NUM_WEIGHTS];
  logic signed [GRAD_W-1:0] gmem [NUM_WEIGHTS];
  logic [IDX_W-1:0]         fbuf [MAX_FEATURES];
  logic signed [WT_W-1:0]   w_rdata_r;
  logic signed [GRAD_W-1:0] g_rdata_r;
  logic [IDX_W-1:0]         b_rdata_r;

  logic [3:0]               state_r, state_nxt;
  logic [AW-1:0]            clr_addr_r;
  logic [CW-1:0]            fcount_r;
  logic [CW-1:0]            gi_r;
  logic signed [SUM_W-1:0]  sum_r;
  logic [LOSS_W-1:0]        loss_r;
  logic [CNT_W-1:0]         rec_r;
  logic                     ovf_r;
  logic                     add_r;
  logic                     last_r;
  logic                     label_r;
  logic                     rd_ok_r;
  logic [AW-1:0]            f_addr_r;
  logic                     out_valid_r;
  logic [OUT_DATA_W-1:0]    out_data_r;
  logic                     out_kind_r;

  op_t                      in_op;
  logic [IDX_W-1:0]         in_idx;
  logic signed [WT_W-1:0]   in_wt;
  logic                     in_label;
  logic                     acc;
  logic                     slot_free;
  logic                     in_ok;
  logic [AW-1:0]            in_addr;
  logic [IDX_W+AW-1:0]      in_ext;
  logic [IDX_W+AW-1:0]      b_ext;
  logic                     b_ok;
  logic [AW-1:0]            b_addr;
  logic [SUM_W:0]           sum_add;
  logic [GRAD_W:0]          g_add;
  logic signed [GRAD_W-1:0] g_new;
  logic signed [17:0]       delta;
  logic [16:0]              q17;
  logic [15:0]              q;
  logic [LOSS_W:0]          loss_add;
  logic [PROB_W-1:0]        p_r;
  logic                     nll_done;
  logic [NLL_W-1:0]         nll;

  assign in_op     = in_tuser;
  assign in_idx    = in_tdata[11:0];
  assign in_wt     = in_tdata[35:12];
  assign in_label  = in_tdata[36];
  assign in_tready = (state_r == ST_IDLE);
  assign acc       = in_tvalid && in_tready;
  assign slot_free = !out_valid_r || out_tready;

  assign in_ext  = {{AW{1'b0}}, in_idx};
  assign in_addr = in_ext[AW-1:0];
  assign in_ok   = (32'(in_idx) < 32'(NUM_WEIGHTS));
  assign b_ext   = {{AW{1'b0}}, b_rdata_r};
  assign b_addr  = b_ext[AW-1:0];
  assign b_ok    = (32'(b_rdata_r) < 32'(NUM_WEIGHTS));

  slg_sigmoid u_sig (
    .clk (clk),
    .en  (state_r == ST_SIG),
    .z   (sum_r),
    .p_r (p_r)
  );

  always_comb begin
    q17 = label_r ? {1'b0, p_r} : (17'h10000 - {1'b0, p_r});
    if (q17 == 17'd0) begin
      q = 16'd1;
    end else if (q17[16]) begin
      q = 16'hFFFF;
    end else begin
      q = q17[15:0];
    end
  end

  slg_nlog u_nlog (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (state_r == ST_LOGS),
    .q      (q),
    .done_r (nll_done),
    .nll_r  (nll)
  );

  always_comb begin
    sum_add  = {sum_r[SUM_W-1], sum_r} + 33'(w_rdata_r);
    delta    = $signed({2'b00, p_r}) - (label_r ? 18'sd65536 : 18'sd0);
    g_add    = {g_rdata_r[GRAD_W-1], g_rdata_r} + 49'(delta);
    if (g_add[GRAD_W] != g_add[GRAD_W-1]) begin
      g_new = g_add[GRAD_W] ? {1'b1, {(GRAD_W-1){1'b0}}} : {1'b0, {(GRAD_W-1){1'b1}}};
    end else begin
      g_new = g_add[GRAD_W-1:0];
    end
    loss_add = {1'b0, loss_r} + 49'(nll);
  end

  // memory ports
  always_ff @(posedge clk) begin
    if (acc && in_op == OP_WRITE && in_ok) begin
      wmem[in_addr] <= in_wt;
    end
    if (acc && in_op == OP_FEATURE) begin
      w_rdata_r <= wmem[in_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_CLR) begin
      gmem[clr_addr_r] <= '0;
    end else if (state_r == ST_GWR) begin
      gmem[f_addr_r] <= g_new;
    end
    if (acc && in_op == OP_READ) begin
      g_rdata_r <= gmem[in_addr];
    end else if (state_r == ST_GRD) begin
      g_rdata_r <= gmem[b_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (acc && in_op == OP_FEATURE && fcount_r < CW'(MAX_FEATURES)) begin
      fbuf[fcount_r[BW-1:0]] <= in_idx;
    end
    if (state_r == ST_GBUF) begin
      b_rdata_r <= fbuf[gi_r[BW-1:0]];
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLR:  if (clr_addr_r == AW'(NUM_WEIGHTS - 1)) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (acc) begin
          case (in_op)
            OP_FEATURE: state_nxt = ST_FADD;
            OP_READ:    state_nxt = ST_RD;
            OP_CLEAR:   state_nxt = ST_CLR;
            default:    state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_FADD: state_nxt = last_r ? ST_SIG : ST_IDLE;
      ST_SIG:  state_nxt = ST_LOGS;
      ST_LOGS: state_nxt = ST_LOGW;
      ST_LOGW: if (nll_done) state_nxt = ST_ACC;
      ST_ACC:  state_nxt = ST_GBUF;
      ST_GBUF: state_nxt = (gi_r < fcount_r) ? ST_GRD : ST_EMIT;
      ST_GRD:  state_nxt = b_ok ? ST_GWR : ST_GBUF;
      ST_GWR:  state_nxt = ST_GBUF;
      ST_EMIT: if (slot_free) state_nxt = ST_IDLE;
      ST_RD:   if (slot_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      clr_addr_r  <= '0;
      fcount_r    <= '0;
      gi_r        <= '0;
      sum_r       <= '0;
      loss_r      <= '0;
      rec_r       <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLR) begin
        clr_addr_r <= clr_addr_r + 1'b1;
      end
      if (acc) begin
        case (in_op)
          OP_FEATURE: begin
            if (fcount_r < CW'(MAX_FEATURES)) begin
              fcount_r <= fcount_r + 1'b1;
            end else begin
              ovf_r <= 1'b1;
            end
          end
          OP_CLEAR: begin
            loss_r     <= '0;
            rec_r      <= '0;
            clr_addr_r <= '0;
          end
          default: ;
        endcase
      end
      if (state_r == ST_FADD && add_r) begin
        if (sum_add[SUM_W] != sum_add[SUM_W-1]) begin
          sum_r <= sum_add[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
        end else begin
          sum_r <= sum_add[SUM_W-1:0];
        end
      end
      if (state_r == ST_ACC) begin
        loss_r <= loss_add[LOSS_W] ? {LOSS_W{1'b1}} : loss_add[LOSS_W-1:0];
        if (rec_r != {CNT_W{1'b1}}) rec_r <= rec_r + 1'b1;
        gi_r <= '0;
      end
      if (state_r == ST_GRD || state_r == ST_GWR) begin
        if (state_r == ST_GWR || !b_ok) gi_r <= gi_r + 1'b1;
      end
      if (state_r == ST_EMIT && slot_free) begin
        fcount_r <= '0;
        sum_r    <= '0;
        ovf_r    <= 1'b0;
      end
      if ((state_r == ST_EMIT || state_r == ST_RD) && slot_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // item side registers, no reset needed
  always_ff @(posedge clk) begin
    if (acc && in_op == OP_FEATURE) begin
      add_r   <= in_ok && (fcount_r < CW'(MAX_FEATURES));
      last_r  <= in_tlast;
      label_r <= in_label;
    end
    if (acc && in_op == OP_READ) begin
      rd_ok_r <= in_ok;
    end
    if (state_r == ST_GRD) begin
      f_addr_r <= b_addr;
    end
    if (state_r == ST_EMIT && slot_free) begin
      out_kind_r <= KIND_PRED;
      out_data_r <= {7'd0, ovf_r, rec_r, loss_r, {GRAD_W{1'b0}}, p_r};
    end else if (state_r == ST_RD && slot_free) begin
      out_kind_r <= KIND_GRAD;
      out_data_r <= {7'd0, 1'b0, rec_r, loss_r,
                     (rd_ok_r ? g_rdata_r : {GRAD_W{1'b0}}), {PROB_W{1'b0}}};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_kind_r;

endmodule

// ----- rtl/slg_sigmoid.sv -----
// ----------------------------------------------------------------------------
// slg_sigmoid
// Piecewise-linear sigmoid of a Q15.16 sum, registered output in Q0.16.
// ----------------------------------------------------------------------------
module slg_sigmoid (
  input  logic                           clk,
  input  logic                           en,
  input  logic signed [slg_pkg::SUM_W-1:0] z,
  output logic [slg_pkg::PROB_W-1:0]     p_r
);
  import slg_pkg::*;

  logic [SUM_W:0]    z_ext;
  logic [SUM_W:0]    mag;
  logic [19:0]       a;
  logic [4:0]        seg;
  logic [14:0]       frac;
  logic [15:0]       base;
  logic [15:0]       diff;
  logic [30:0]       prod;
  logic [16:0]       pos;
  logic [PROB_W-1:0] p_nxt;

  always_comb begin
    z_ext = {z[SUM_W-1], z};
    mag   = z[SUM_W-1] ? (~z_ext + 1'b1) : z_ext;
    // magnitude saturates at 8.0
    a     = (mag > 33'd524288) ? 20'd524288 : mag[19:0];
    seg   = a[19:15];
    frac  = a[14:0];
    base  = sig_point(seg);
    diff  = (seg >= 5'd16) ? 16'd0 : (sig_point(seg + 5'd1) - base);
    prod  = 31'(diff) * 31'(frac);
    pos   = 17'(base) + 17'(prod[30:15]);
    p_nxt = z[SUM_W-1] ? 16'(17'h10000 - pos) : pos[15:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= p_nxt;
    end
  end

endmodule

// ----- rtl/slg_nlog.sv -----
// ----------------------------------------------------------------------------
// slg_nlog
// Iterative -ln(q/65536) unit: bit-serial log2 by squaring, then times ln2.
// ----------------------------------------------------------------------------
module slg_nlog (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [15:0]                q,
  output logic                       done_r,
  output logic [slg_pkg::NLL_W-1:0]  nll_r
);
  import slg_pkg::*;

  logic        run_r, run_nxt;
  logic        mul_r, mul_nxt;
  logic [3:0]  cnt_r;
  logic [3:0]  k_r;
  logic [15:0] frac_r;
  logic [16:0] m_r;
  logic [3:0]  k_lz;
  logic [33:0] sq;
  logic [17:0] s;
  logic [20:0] r;
  logic [36:0] prod;

  always_comb begin
    k_lz = 4'd0;
    for (int i = 0; i < 16; i++) begin
      if (q[i]) k_lz = 4'(i);
    end
    sq   = 34'(m_r) * 34'(m_r);
    s    = sq[33:16];
    r    = 21'(32'd16 << 16) - {1'b0, k_r, frac_r};
    prod = 37'(r) * 37'(LN2_Q16) + 37'd32768;
    run_nxt = run_r;
    mul_nxt = 1'b0;
    if (start) begin
      run_nxt = 1'b1;
    end else if (run_r && cnt_r == 4'd0) begin
      run_nxt = 1'b0;
      mul_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      mul_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      mul_r  <= mul_nxt;
      done_r <= mul_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      k_r    <= k_lz;
      m_r    <= 17'({1'b0, q} << (5'd16 - {1'b0, k_lz}));
      frac_r <= 16'd0;
      cnt_r  <= 4'd15;
    end else if (run_r) begin
      if (s[17]) begin
        m_r           <= s[17:1];
        frac_r[cnt_r] <= 1'b1;
      end else begin
        m_r <= s[16:0];
      end
      cnt_r <= cnt_r - 4'd1;
    end
    if (mul_r) begin
      nll_r <= prod[36:16];
    end
  end

endmodule

// ----- rtl/slg_checker.sv -----
// ----------------------------------------------------------------------------
// slg_port_props
// Port-level checks of the sparse logistic gradient engine.
// ----------------------------------------------------------------------------
module slg_port_props (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tvalid,
  input logic                           in_tready,
  input logic [slg_pkg::IN_DATA_W-1:0]  in_tdata,
  input logic [slg_pkg::IN_USER_W-1:0]  in_tuser,
  input logic                           in_tlast,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [slg_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic [slg_pkg::OUT_USER_W-1:0] out_tuser
);
  import slg_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  a_grad_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] == KIND_GRAD |->
      out_tdata[15:0] == 16'd0 && out_tdata[144] == 1'b0)
    else $error("gradient result carries prediction fields");

  a_pred_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] == KIND_PRED |->
      out_tdata[63:16] == 48'd0 && out_tdata[143:112] != 32'd0)
    else $error("prediction result malformed");

endmodule

bind sparse_logistic_gradient_top slg_port_props u_slg_port_props (.*);
